// ----- hdl/xtl_pkg.sv -----
// xtl_pkg: shared widths, register indices and control types for the xyb to linear rgb block
// no dependencies; imported by every module under hdl
`timescale 1ns / 1ps

package xtl_pkg;

	localparam int IN_W    = 20;   // xyb component, signed q3.16
	localparam int CH_W    = 21;   // packed coefficient field, signed q4.16
	localparam int REG_W   = 63;   // three packed fields
	localparam int SCALE_W = 24;   // unsigned q8.16
	localparam int OUT_W   = 24;   // linear rgb, signed q7.16
	localparam int DATA_W  = 64;   // apb data
	localparam int ADDR_W  = 6;    // six registers at 8 byte spacing
	localparam int IDX_W   = 3;

	// widths along a lane
	localparam int G_W     = CH_W + 1;        // channel minus cube root bias
	localparam int SQ_W    = 28;              // rounded square, at most 2^26
	localparam int CUBE_W  = 34;              // rounded cube
	localparam int SUM_W   = CUBE_W + 1;      // cube plus bias
	localparam int V_W     = 44;              // scaled channel
	localparam int TERM_W  = CH_W + V_W;      // coefficient times channel
	localparam int ACC_W   = TERM_W + 2;      // sum of three terms

	localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(65536);

	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	typedef enum logic [IDX_W-1:0] {
		IDX_MAT0  = 3'd0,
		IDX_MAT1  = 3'd1,
		IDX_MAT2  = 3'd2,
		IDX_BIAS  = 3'd3,
		IDX_CBRT  = 3'd4,
		IDX_SCALE = 3'd5
	} cfg_idx_e;

	typedef struct packed {
		logic [2:0][REG_W-1:0] mat_row;
		logic [REG_W-1:0]      bias;
		logic [REG_W-1:0]      cbrt_bias;
		logic [SCALE_W-1:0]    scale;
	} cfg_t;

	// load enables of the six pipeline stages
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} pipe_en_t;

endpackage

// ----- hdl/xtl_cfg.sv -----
// xtl_cfg: apb register file holding matrix rows, biases and intensity scale
// depends on xtl_pkg
`timescale 1ns / 1ps

module xtl_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [xtl_pkg::ADDR_W-1:0]   paddr,
	input  logic [xtl_pkg::DATA_W-1:0]   pwdata,
	output logic [xtl_pkg::DATA_W-1:0]   prdata,
	output xtl_pkg::cfg_t                cfg
);
	import xtl_pkg::*;

	cfg_t     cfg_q;
	cfg_idx_e idx;
	logic     wr;

	assign idx = cfg_idx_e'(paddr[ADDR_W-1:ADDR_W-IDX_W]);
	assign wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mat_row   <= '0;
			cfg_q.bias      <= '0;
			cfg_q.cbrt_bias <= '0;
			cfg_q.scale     <= SCALE_RST;
		end else if (wr) begin
			case (idx)
				IDX_MAT0:  cfg_q.mat_row[0] <= pwdata[REG_W-1:0];
				IDX_MAT1:  cfg_q.mat_row[1] <= pwdata[REG_W-1:0];
				IDX_MAT2:  cfg_q.mat_row[2] <= pwdata[REG_W-1:0];
				IDX_BIAS:  cfg_q.bias       <= pwdata[REG_W-1:0];
				IDX_CBRT:  cfg_q.cbrt_bias  <= pwdata[REG_W-1:0];
				IDX_SCALE: cfg_q.scale      <= pwdata[SCALE_W-1:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			IDX_MAT0:  prdata = DATA_W'(cfg_q.mat_row[0]);
			IDX_MAT1:  prdata = DATA_W'(cfg_q.mat_row[1]);
			IDX_MAT2:  prdata = DATA_W'(cfg_q.mat_row[2]);
			IDX_BIAS:  prdata = DATA_W'(cfg_q.bias);
			IDX_CBRT:  prdata = DATA_W'(cfg_q.cbrt_bias);
			IDX_SCALE: prdata = DATA_W'(cfg_q.scale);
			default:   prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ----- hdl/xtl_lane.sv -----
// xtl_lane: one opsin channel, bias removal, cube, bias add and intensity scale over four stages
// depends on xtl_pkg
`timescale 1ns / 1ps

module xtl_lane (
	input  logic                              clk,
	input  xtl_pkg::pipe_en_t                 en,
	input  logic signed [xtl_pkg::CH_W-1:0]   ch,
	input  logic signed [xtl_pkg::CH_W-1:0]   cbrt_bias,
	input  logic signed [xtl_pkg::CH_W-1:0]   bias,
	input  logic [xtl_pkg::SCALE_W-1:0]       scale,
	output logic signed [xtl_pkg::V_W-1:0]    v
);
	import xtl_pkg::*;

	localparam int GG_W = 2 * G_W;
	localparam int P_W  = SQ_W + G_W;
	localparam int SP_W = SUM_W + SCALE_W + 1;

	logic signed [G_W-1:0]    g_s1, g_s2;
	logic signed [SQ_W-1:0]   sq_s2;
	logic signed [SUM_W-1:0]  sum_s3;
	logic signed [V_W-1:0]    v_s4;

	logic signed [GG_W-1:0]   gg;
	logic signed [GG_W:0]     gg_r;
	logic signed [P_W-1:0]    p;
	logic signed [P_W:0]      p_r;
	logic signed [SP_W-1:0]   sp;
	logic signed [SP_W:0]     sp_r;

	// half an lsb added, then floor by arithmetic shift
	assign gg   = g_s1 * g_s1;
	assign gg_r = GG_W'(gg) + (GG_W+1)'(32768);
	assign p    = sq_s2 * P_W'(g_s2);
	assign p_r  = (P_W+1)'(p) + (P_W+1)'(32768);
	assign sp   = SP_W'(sum_s3) * $signed({1'b0, scale});
	assign sp_r = (SP_W+1)'(sp) + (SP_W+1)'(32768);

	always_ff @(posedge clk) begin
		if (en.s1) begin
			g_s1 <= G_W'(ch) - G_W'(cbrt_bias);
		end
		if (en.s2) begin
			sq_s2 <= gg_r[SQ_W+15:16];
			g_s2  <= g_s1;
		end
		if (en.s3) begin
			sum_s3 <= SUM_W'($signed(p_r[CUBE_W+15:16])) + SUM_W'(bias);
		end
		if (en.s4) begin
			v_s4 <= sp_r[V_W+15:16];
		end
	end

	assign v = v_s4;

endmodule

// ----- hdl/xtl_matrix.sv -----
// xtl_matrix: 3x3 inverse opsin matrix, products then rounded and saturated sums
// depends on xtl_pkg
`timescale 1ns / 1ps

module xtl_matrix (
	input  logic                                 clk,
	input  xtl_pkg::pipe_en_t                    en,
	input  logic [2:0][xtl_pkg::REG_W-1:0]       mat_row,
	input  logic signed [xtl_pkg::V_W-1:0]       v0,
	input  logic signed [xtl_pkg::V_W-1:0]       v1,
	input  logic signed [xtl_pkg::V_W-1:0]       v2,
	output logic [2:0][xtl_pkg::OUT_W-1:0]       rgb
);
	import xtl_pkg::*;

	localparam int RND_W = ACC_W - 16;

	logic signed [TERM_W-1:0] term_s5 [3][3];
	logic [2:0][OUT_W-1:0]    rgb_s6;
	logic signed [V_W-1:0]    v [3];
	logic signed [ACC_W-1:0]  acc [3];
	logic signed [RND_W-1:0]  rnd [3];
	logic [2:0][OUT_W-1:0]    sat;

	assign v[0] = v0;
	assign v[1] = v1;
	assign v[2] = v2;

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++) begin
				if (en.s5) begin
					term_s5[r][k] <= TERM_W'($signed(mat_row[r][k*CH_W +: CH_W])) *
					                 TERM_W'(v[k]);
				end
			end
		end
		if (en.s6) begin
			rgb_s6 <= sat;
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			acc[r] = ACC_W'(term_s5[r][0]) + ACC_W'(term_s5[r][1]) +
			         ACC_W'(term_s5[r][2]) + ACC_W'(32768);
			rnd[r] = acc[r][ACC_W-1:16];
			if (rnd[r] > RND_W'(OUT_MAX)) begin
				sat[r] = OUT_MAX;
			end else if (rnd[r] < RND_W'(OUT_MIN)) begin
				sat[r] = OUT_MIN;
			end else begin
				sat[r] = rnd[r][OUT_W-1:0];
			end
		end
	end

	assign rgb = rgb_s6;

endmodule

// ----- hdl/xyb_to_linear_rgb.sv -----
// xyb_to_linear_rgb: top level, stream handshake, stage valids and last flags
// depends on xtl_pkg, xtl_cfg, xtl_lane, xtl_matrix
`timescale 1ns / 1ps
//
// channel   | direction | signals                         | contents
// ----------+-----------+---------------------------------+-------------------------------
// s_*       | in        | s_tvalid s_tready s_tdata s_tlast | one xyb pixel word, last pixel
// m_*       | out       | m_tvalid m_tready m_tdata m_tlast | one linear rgb word, last flag
// apb       | in / out  | psel penable pwrite paddr ...   | six registers at 8 byte spacing
//
// one word per clock is sustained while the output is not stalled
// the six stages are the cube root bias subtraction, the lane multipliers (square, cube,
// scale), the matrix products, and the rounded, saturated sums in the output register
// each stage loads when it is empty or the stage after it moves, so a stall on the
// output fills bubbles first and nothing is dropped or repeated
// reset clears the stage valids and the registers; the data path carries no reset

module xyb_to_linear_rgb (
	input  logic                         clk,
	input  logic                         arst_n,
	// slave side
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [63:0]                  s_tdata,   // x_chroma[19:0], y_luma[39:20], b_chroma[59:40], zeros
	input  logic                         s_tlast,   // last_pixel
	// master side
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [71:0]                  m_tdata,   // red_lin[23:0], green_lin[47:24], blue_lin[71:48]
	output logic                         m_tlast,   // last_out
	// configuration
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [xtl_pkg::ADDR_W-1:0]   paddr,
	input  logic [xtl_pkg::DATA_W-1:0]   pwdata,
	output logic [xtl_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);
	import xtl_pkg::*;

	cfg_t     cfg;
	pipe_en_t en;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic last_s1, last_s2, last_s3, last_s4, last_s5, last_s6;

	logic signed [IN_W-1:0]  x_chroma, y_luma, b_chroma;
	logic signed [CH_W-1:0]  ch [3];
	logic signed [V_W-1:0]   v [3];
	logic [2:0][OUT_W-1:0]   rgb;

	assign pready = 1'b1;

	xtl_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// stall chain, back to front: a stage loads when empty or when its successor loads
	assign en.s6    = !valid_s6 || m_tready;
	assign en.s5    = !valid_s5 || en.s6;
	assign en.s4    = !valid_s4 || en.s5;
	assign en.s3    = !valid_s3 || en.s4;
	assign en.s2    = !valid_s2 || en.s3;
	assign en.s1    = !valid_s1 || en.s2;
	assign s_tready = en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (en.s1) valid_s1 <= s_tvalid;
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
			if (en.s4) valid_s4 <= valid_s3;
			if (en.s5) valid_s5 <= valid_s4;
			if (en.s6) valid_s6 <= valid_s5;
		end
	end

	// last flag rides alongside the data
	always_ff @(posedge clk) begin
		if (en.s1) last_s1 <= s_tlast;
		if (en.s2) last_s2 <= last_s1;
		if (en.s3) last_s3 <= last_s2;
		if (en.s4) last_s4 <= last_s3;
		if (en.s5) last_s5 <= last_s4;
		if (en.s6) last_s6 <= last_s5;
	end

	// opsin channels: l = y + x, m = y - x, s = b
	assign x_chroma = s_tdata[IN_W-1:0];
	assign y_luma   = s_tdata[2*IN_W-1:IN_W];
	assign b_chroma = s_tdata[3*IN_W-1:2*IN_W];
	assign ch[0]    = CH_W'(y_luma) + CH_W'(x_chroma);
	assign ch[1]    = CH_W'(y_luma) - CH_W'(x_chroma);
	assign ch[2]    = CH_W'(b_chroma);

	for (genvar k = 0; k < 3; k++) begin : g_lane
		xtl_lane u_lane (
			.clk       (clk),
			.en        (en),
			.ch        (ch[k]),
			.cbrt_bias ($signed(cfg.cbrt_bias[k*CH_W +: CH_W])),
			.bias      ($signed(cfg.bias[k*CH_W +: CH_W])),
			.scale     (cfg.scale),
			.v         (v[k])
		);
	end

	xtl_matrix u_matrix (
		.clk     (clk),
		.en      (en),
		.mat_row (cfg.mat_row),
		.v0      (v[0]),
		.v1      (v[1]),
		.v2      (v[2]),
		.rgb     (rgb)
	);

	assign m_tvalid = valid_s6;
	assign m_tlast  = last_s6;
	assign m_tdata  = rgb;

`ifndef SYNTHESIS
	// an empty output stage means the whole pipe can move
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while output stage empty");

	// a new output word must come from a full stage five
	a_out_from_s5: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !$past(m_tvalid)) |-> $past(valid_s5))
		else $error("output word appeared without a word in stage five");

	// a write to the scale register is in force from the next edge
	a_scale_write: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && paddr[ADDR_W-1:ADDR_W-IDX_W] == IDX_SCALE)
		|=> cfg.scale == $past(pwdata[SCALE_W-1:0]))
		else $error("intensity scale not taken from write");
`endif

endmodule

// ----- sim/xyb_to_linear_rgb_tb.sv -----
`timescale 1ns / 1ps
// xyb_to_linear_rgb_tb: self-checking bench for the xyb to linear rgb converter
// streams pixels, writes the registers over apb, predicts each output word and compares
// depends on xtl_pkg and xyb_to_linear_rgb under hdl

module xyb_to_linear_rgb_tb;

	import xtl_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;   // quiet cycles before the run is abandoned
	localparam int PIPE_TAIL      = 16;     // settle time once nothing is due
	localparam int LONG_HOLD      = 400;    // receiver hold-off that backs up the pipe
	localparam int RAND_PER_PHASE = 230;
	localparam int N_PHASES       = 8;

	// addresses past the register list, writes there must change nothing
	localparam logic [IDX_W-1:0] IDX_SPARE0 = 3'd6;
	localparam logic [IDX_W-1:0] IDX_SPARE1 = 3'd7;

	localparam int IN_MAX = 524287;
	localparam int IN_MIN = -524288;
	localparam int CH_MAX = 1048575;        // largest q4.16 field
	localparam int CH_MIN = -1048576;
	localparam int UNIT   = 65536;          // 1.0 in q.16
	localparam logic [63:0] TOP_BIT = 64'h8000_0000_0000_0000;

	// approximate inverse opsin matrix and biases, q4.16
	localparam int OP_00 = 722965,  OP_01 = -646641, OP_02 = -10789;
	localparam int OP_10 = -213264, OP_11 = 289588,  OP_12 = -10789;
	localparam int OP_20 = -239786, OP_21 = 177794,  OP_22 = 127528;
	localparam int OP_BIAS = -249;
	localparam int OP_CBRT = -10221;

	localparam int SCALE_255_80  = 208896;   // 255 / 80
	localparam int SCALE_NO_TGT  = 16711680; // 255, target not positive

	typedef struct {
		logic signed [IN_W-1:0] x;
		logic signed [IN_W-1:0] y;
		logic signed [IN_W-1:0] b;
		logic                   last;
	} xyb_pixel_t;

	typedef struct {
		logic signed [OUT_W-1:0] r;
		logic signed [OUT_W-1:0] g;
		logic signed [OUT_W-1:0] b;
		logic                    last;
	} rgb_word_t;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [63:0]       s_tdata  = '0;     // x_chroma[19:0], y_luma[39:20], b_chroma[59:40], zeros
	logic              s_tlast  = 1'b0;   // last_pixel
	logic              m_tvalid;
	logic              m_tready = 1'b1;
	logic [71:0]       m_tdata;           // red_lin[23:0], green_lin[47:24], blue_lin[71:48]
	logic              m_tlast;           // last_out
	logic              psel     = 1'b0;
	logic              penable  = 1'b0;
	logic              pwrite   = 1'b0;
	logic [ADDR_W-1:0] paddr    = '0;
	logic [DATA_W-1:0] pwdata   = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	// bench copy of the register file, as it stands after reset
	logic [REG_W-1:0]   coef_row [3] = '{default: '0};
	logic [REG_W-1:0]   post_bias    = '0;
	logic [REG_W-1:0]   cbrt_bias    = '0;
	logic [SCALE_W-1:0] intensity_q16 = SCALE_RST;

	xyb_pixel_t pixel_q [$];      // pixels waiting for the driver
	rgb_word_t  rgb_due_q [$];    // predicted words, oldest first
	xyb_pixel_t pixel_on_bus;     // the pixel currently offered

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int err_count      = 0;
	int quiet_cycles   = 0;
	int hold_left      = 0;
	bit hold_armed     = 1'b0;
	bit hold_done      = 1'b0;

	xyb_to_linear_rgb u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---------------------------------------------------------------- prediction

	// signed q4.16 field k of a packed register
	function automatic longint coef_at(logic [REG_W-1:0] row_bits, int k);
		logic signed [CH_W-1:0] f;
		f = row_bits[k*CH_W +: CH_W];
		return longint'(f);
	endfunction

	// drop 16 fraction bits, half rounds up
	function automatic longint round_q16(longint v);
		return (v + 64'sd32768) >>> 16;
	endfunction

	// full conversion of one pixel against the current register copy
	function automatic rgb_word_t linear_rgb_of(xyb_pixel_t p);
		longint lms [3];
		longint lin [3];
		longint g, sq, cube, acc;
		logic signed [OUT_W-1:0] rgb [3];
		rgb_word_t w;
		// l = y + x, m = y - x, s = b
		lms[0] = longint'(p.y) + longint'(p.x);
		lms[1] = longint'(p.y) - longint'(p.x);
		lms[2] = longint'(p.b);
		for (int k = 0; k < 3; k++) begin
			g      = lms[k] - coef_at(cbrt_bias, k);
			sq     = round_q16(g * g);
			cube   = round_q16(sq * g);
			lin[k] = round_q16((cube + coef_at(post_bias, k)) *
				longint'({1'b0, intensity_q16}));
		end
		// matrix product, then clamp to the 24 bit output range
		for (int r = 0; r < 3; r++) begin
			acc = 0;
			for (int k = 0; k < 3; k++)
				acc += coef_at(coef_row[r], k) * lin[k];
			acc = round_q16(acc);
			if (acc > longint'(OUT_MAX))
				rgb[r] = OUT_MAX;
			else if (acc < longint'(OUT_MIN))
				rgb[r] = OUT_MIN;
			else
				rgb[r] = acc[OUT_W-1:0];
		end
		w.r    = rgb[0];
		w.g    = rgb[1];
		w.b    = rgb[2];
		w.last = p.last;
		return w;
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	function automatic logic [63:0] pack3(int c0, int c1, int c2);
		logic [CH_W-1:0] f0, f1, f2;
		f0 = CH_W'(c0);
		f1 = CH_W'(c1);
		f2 = CH_W'(c2);
		return {1'b0, f2, f1, f0};
	endfunction

	// random q4.16 value in [-span, span]
	function automatic int rand_q416(int span);
		return int'($urandom_range(2 * span)) - span;
	endfunction

	task automatic queue_pixel(input int x, input int y, input int b, input bit last);
		xyb_pixel_t p;
		p.x    = IN_W'(x);
		p.y    = IN_W'(y);
		p.b    = IN_W'(b);
		p.last = last;
		pixel_q.push_back(p);
	endtask

	// apb write: setup cycle, then access until pready; the copy follows the write
	task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [63:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			IDX_MAT0:  coef_row[0]   = val[REG_W-1:0];
			IDX_MAT1:  coef_row[1]   = val[REG_W-1:0];
			IDX_MAT2:  coef_row[2]   = val[REG_W-1:0];
			IDX_BIAS:  post_bias     = val[REG_W-1:0];
			IDX_CBRT:  cbrt_bias     = val[REG_W-1:0];
			IDX_SCALE: intensity_q16 = val[SCALE_W-1:0];
			default: ;  // nothing lives there
		endcase
	endtask

	task automatic load_cfg(input logic [63:0] m0, input logic [63:0] m1,
		input logic [63:0] m2, input logic [63:0] bias, input logic [63:0] cbrt,
		input logic [63:0] scale);
		cfg_write(IDX_MAT0, m0);
		cfg_write(IDX_MAT1, m1);
		cfg_write(IDX_MAT2, m2);
		cfg_write(IDX_BIAS, bias);
		cfg_write(IDX_CBRT, cbrt);
		cfg_write(IDX_SCALE, scale);
	endtask

	// sender holds back until every predicted word has come out, then a short tail
	task automatic wait_drained();
		do @(negedge clk); while (pixel_q.size() != 0 || s_tvalid || rgb_due_q.size() != 0);
		repeat (PIPE_TAIL) @(negedge clk);
	endtask

	task automatic check_field(input string what, input logic [OUT_W-1:0] want,
		input logic [OUT_W-1:0] got);
		if (want !== got) begin
			err_count++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
		end
	endtask

	// ---------------------------------------------------------------- driver

	// a new word goes out once the previous one is taken; the prediction is made at
	// the edge that accepts the word, so it sees the registers in force then
	always @(posedge clk) begin : pixel_drv
		xyb_pixel_t nxt;
		if (s_tvalid && s_tready)
			rgb_due_q.push_back(linear_rgb_of(pixel_on_bus));
		if (!s_tvalid || s_tready) begin
			if (arst_n && pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = pixel_q.pop_front();
				pixel_on_bus <= nxt;
				s_tdata      <= {4'b0000, nxt.b, nxt.y, nxt.x};
				s_tlast      <= nxt.last;
				s_tvalid     <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	// compares each output word with the oldest prediction and decides tready;
	// once armed, the first word on offer starts one long hold-off so the pipe fills
	always @(posedge clk) begin : result_mon
		rgb_word_t want;
		if (m_tvalid && m_tready) begin
			if (rgb_due_q.size() == 0) begin
				err_count++;
				$display("%0t: output word with none due, expected nothing, actual %h",
					$time, m_tdata);
			end else begin
				want = rgb_due_q.pop_front();
				check_field("red_lin",   want.r, m_tdata[OUT_W-1:0]);
				check_field("green_lin", want.g, m_tdata[2*OUT_W-1:OUT_W]);
				check_field("blue_lin",  want.b, m_tdata[3*OUT_W-1:2*OUT_W]);
				check_field("last_out",  OUT_W'(want.last), OUT_W'(m_tlast));
			end
		end
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else if (hold_armed && !hold_done && m_tvalid) begin
			hold_left <= LONG_HOLD;
			hold_done <= 1'b1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// ---------------------------------------------------------------- watchdog

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------- test sequence

	initial begin
		xyb_pixel_t px;
		int pick;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: zero matrix, so every word must come out zero
		queue_pixel(IN_MAX, IN_MAX, IN_MAX, 1'b1);
		queue_pixel(IN_MIN, IN_MIN, IN_MIN, 1'b0);
		queue_pixel(0, 0, 0, 1'b1);
		wait_drained();

		// opsin inverse at unit scale, field extremes and saturation both ways
		load_cfg(pack3(OP_00, OP_01, OP_02), pack3(OP_10, OP_11, OP_12),
			pack3(OP_20, OP_21, OP_22), pack3(OP_BIAS, OP_BIAS, OP_BIAS),
			pack3(OP_CBRT, OP_CBRT, OP_CBRT), 64'(UNIT));
		queue_pixel(IN_MAX, IN_MAX, IN_MAX, 1'b1);
		queue_pixel(IN_MIN, IN_MIN, IN_MIN, 1'b0);
		queue_pixel(IN_MAX, IN_MIN, 0, 1'b1);
		queue_pixel(IN_MIN, IN_MAX, IN_MAX, 1'b0);
		queue_pixel(0, IN_MAX, 0, 1'b1);
		queue_pixel(0, IN_MIN, IN_MIN, 1'b0);
		queue_pixel(0, 0, 0, 1'b0);
		queue_pixel(1, -1, 1, 1'b1);
		queue_pixel(-1, 1, -1, 1'b0);
		queue_pixel(UNIT, UNIT, UNIT, 1'b0);
		queue_pixel(0, UNIT / 2, 0, 1'b1);
		queue_pixel(-UNIT, 0, UNIT, 1'b0);
		queue_pixel(12345, -23456, 34567, 1'b1);
		queue_pixel(-4096, 40000, -20000, 1'b0);
		queue_pixel(IN_MAX, 0, IN_MIN, 1'b1);
		queue_pixel(UNIT, -UNIT, 0, 1'b0);
		wait_drained();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			// idling pattern of this phase
			case (ph % 4)
				0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1:       begin send_idle_pct = 49; recv_stall_pct = 0;  end
				2:       begin send_idle_pct = 0;  recv_stall_pct = 49; end
				default: begin send_idle_pct = 12; recv_stall_pct = 12; end
			endcase

			// register setting of this phase, only while the block is empty
			case (ph)
				0: load_cfg(pack3(OP_00, OP_01, OP_02), pack3(OP_10, OP_11, OP_12),
					pack3(OP_20, OP_21, OP_22), pack3(OP_BIAS, OP_BIAS, OP_BIAS),
					pack3(OP_CBRT, OP_CBRT, OP_CBRT), 64'(UNIT));
				1: begin
					// extreme fields and largest scale, with junk in the unused upper bits
					load_cfg(pack3(CH_MAX, CH_MAX, CH_MAX) | TOP_BIT,
						pack3(CH_MAX, CH_MAX, CH_MAX) | TOP_BIT,
						pack3(CH_MAX, CH_MAX, CH_MAX) | TOP_BIT,
						pack3(CH_MAX, CH_MAX, CH_MAX) | TOP_BIT,
						pack3(CH_MIN, CH_MIN, CH_MIN) | TOP_BIT,
						64'hFFFF_FFFF_FFFF_FFFF);
					cfg_write(IDX_SPARE0, '1);
					cfg_write(IDX_SPARE1, {$urandom, $urandom});
				end
				2: load_cfg(pack3(CH_MIN, CH_MIN, CH_MIN), pack3(CH_MIN, CH_MIN, CH_MIN),
					pack3(CH_MIN, CH_MIN, CH_MIN), pack3(CH_MIN, CH_MIN, CH_MIN),
					pack3(CH_MAX, CH_MAX, CH_MAX), '0);
				3: load_cfg(pack3(OP_00, OP_01, OP_02), pack3(OP_10, OP_11, OP_12),
					pack3(OP_20, OP_21, OP_22), pack3(OP_BIAS, OP_BIAS, OP_BIAS),
					pack3(OP_CBRT, OP_CBRT, OP_CBRT), 64'(SCALE_NO_TGT));
				5: begin
					// anything at all, top bits included
					load_cfg({$urandom, $urandom}, {$urandom, $urandom},
						{$urandom, $urandom}, {$urandom, $urandom},
						{$urandom, $urandom}, {$urandom, $urandom});
					cfg_write(IDX_SPARE0, {$urandom, $urandom});
				end
				6: load_cfg(pack3(OP_00, OP_01, OP_02), pack3(OP_10, OP_11, OP_12),
					pack3(OP_20, OP_21, OP_22), pack3(OP_BIAS, OP_BIAS, OP_BIAS),
					pack3(OP_CBRT, OP_CBRT, OP_CBRT), 64'(SCALE_255_80));
				default:
					// moderate coefficients, closer to real colour work
					load_cfg(pack3(rand_q416(4 * UNIT), rand_q416(4 * UNIT), rand_q416(4 * UNIT)),
						pack3(rand_q416(4 * UNIT), rand_q416(4 * UNIT), rand_q416(4 * UNIT)),
						pack3(rand_q416(4 * UNIT), rand_q416(4 * UNIT), rand_q416(4 * UNIT)),
						pack3(rand_q416(UNIT / 8), rand_q416(UNIT / 8), rand_q416(UNIT / 8)),
						pack3(rand_q416(UNIT / 2), rand_q416(UNIT / 2), rand_q416(UNIT / 2)),
						64'($urandom_range(4 * UNIT)));
			endcase

			// the first phase also backs the pipe up behind one long receiver hold-off
			if (ph == 0)
				hold_armed = 1'b1;

			for (int n = 0; n < RAND_PER_PHASE; n++) begin
				pick = $urandom_range(3);
				if (pick == 0) begin
					// whole field range, reaches saturation and every bit
					px.x = IN_W'($urandom);
					px.y = IN_W'($urandom);
					px.b = IN_W'($urandom);
				end else begin
					// typical image content, magnitude up to about one
					px.x = IN_W'(int'($urandom_range(2 * UNIT)) - UNIT);
					px.y = IN_W'(int'($urandom_range(2 * UNIT)) - UNIT);
					px.b = IN_W'(int'($urandom_range(2 * UNIT)) - UNIT);
				end
				px.last = ($urandom_range(15) == 0);
				pixel_q.push_back(px);
			end
			wait_drained();
		end

		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
